/* rtl/pwr_pkg.sv */
// Shared types, constants and helpers of the prefix-walk range builder.
`default_nettype none

package pwr_pkg;

  localparam int AddrW  = 32;
  localparam int LenW   = 8;
  localparam int ValueW = 16;
  localparam int CmdW   = 2;
  localparam int Levels = 33;
  localparam int MaxLen = 32;
  localparam int DepthW = $clog2(Levels);

  typedef enum logic [CmdW-1:0] {
    CMD_PRE    = 2'd0,
    CMD_POST   = 2'd1,
    CMD_FINISH = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [CmdW-1:0]   command;
    logic [AddrW-1:0]  prefix_addr;
    logic [LenW-1:0]   prefix_len;
    logic [ValueW-1:0] value_id;
  } in_item_t;

  typedef struct packed {
    logic [AddrW-1:0]  range_start;
    logic [AddrW-1:0]  range_end;
    logic [ValueW-1:0] range_value;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PRE_RD,
    ST_PRE_FILL,
    ST_POST_DEPTH,
    ST_POST_RD,
    ST_UPDATE,
    ST_FLUSH
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic prep;
    logic rd_level;
    logic fill_step;
    logic set_level;
    logic post_depth;
    logic update;
    logic flush;
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic is_pre;
    logic is_post;
    logic is_finish;
    logic item_ok;
    logic wraps;
    logic depth_lt_len;
    logic out_free;
  } sts_t;

  // Count trailing zeros by halving; a zero word gives all ones.
  function automatic logic [4:0] trailing_zeros(logic [AddrW-1:0] x);
    logic [AddrW-1:0] v;
    logic [4:0]       n;
    v = x;
    n = '0;
    if (v[15:0] == 16'h0) begin
      n[4] = 1'b1;
      v    = v >> 16;
    end
    if (v[7:0] == 8'h0) begin
      n[3] = 1'b1;
      v    = v >> 8;
    end
    if (v[3:0] == 4'h0) begin
      n[2] = 1'b1;
      v    = v >> 4;
    end
    if (v[1:0] == 2'h0) begin
      n[1] = 1'b1;
      v    = v >> 2;
    end
    if (v[0] == 1'b0) begin
      n[0] = 1'b1;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

/* rtl/pwr_stream_if.sv */
// Valid/ready stream channel with a typed payload.
`default_nettype none

interface pwr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/pwr_ctrl.sv */
// Sequencing state machine of the prefix-walk range builder.
`default_nettype none

module pwr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pwr_pkg::sts_t sts_i,
  output pwr_pkg::ctl_t ctl_o
);
  import pwr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        ctl_o.prep = 1'b1;
        priority if (sts_i.is_finish) begin
          state_d = ST_FLUSH;
        end else if (!sts_i.item_ok) begin
          state_d = ST_IDLE;
        end else if (sts_i.is_pre) begin
          state_d = ST_PRE_RD;
        end else if (sts_i.is_post && !sts_i.wraps) begin
          state_d = ST_POST_DEPTH;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_PRE_RD: begin
        ctl_o.rd_level = 1'b1;
        state_d        = ST_PRE_FILL;
      end
      ST_PRE_FILL: begin
        // copy the inherited value upwards one level a cycle, then set own level
        if (sts_i.depth_lt_len) begin
          ctl_o.fill_step = 1'b1;
        end else begin
          ctl_o.set_level = 1'b1;
          state_d         = ST_UPDATE;
        end
      end
      ST_POST_DEPTH: begin
        ctl_o.post_depth = 1'b1;
        state_d          = ST_POST_RD;
      end
      ST_POST_RD: begin
        ctl_o.rd_level = 1'b1;
        state_d        = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (sts_i.out_free) begin
          ctl_o.update = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (sts_i.out_free) begin
          ctl_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/pwr_datapath.sv */
// Item registers, level stack, address stepping and range merging.
`default_nettype none

module pwr_datapath #(
  parameter int VALUE_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pwr_pkg::in_item_t  item_i,
  input  pwr_pkg::ctl_t      ctl_i,
  output pwr_pkg::sts_t      sts_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output pwr_pkg::out_item_t out_item_o
);
  import pwr_pkg::*;

  localparam int StoreW = (VALUE_BITS < ValueW) ? VALUE_BITS : ValueW;

  // item registers
  logic [CmdW-1:0]   cmd_q;
  logic [AddrW-1:0]  addr_q;
  logic [LenW-1:0]   len_q;
  logic [StoreW-1:0] val_q;

  // level stack
  logic [StoreW-1:0] mem [Levels];
  logic [Levels-1:0] valid_q;
  logic [StoreW-1:0] rd_q;
  logic              rdv_q;
  logic [DepthW-1:0] depth_q;

  // open range and output register
  logic [AddrW-1:0]  open_start_q;
  logic [StoreW-1:0] open_val_q;
  logic              out_valid_q;
  out_item_t         out_q;

  logic              len_ok;
  logic [DepthW-1:0] len6;
  logic [AddrW-1:0]  mask;
  logic [AddrW-1:0]  maddr;
  logic [AddrW:0]    step;
  logic [AddrW:0]    sum;
  logic              is_pre, is_post, is_finish;
  logic              mem_we;
  logic [DepthW-1:0] mem_waddr;
  logic [StoreW-1:0] mem_wdata;
  logic [StoreW-1:0] fill_val;
  logic [StoreW-1:0] new_val;
  logic              emit;
  logic              out_free;

  assign is_pre    = (cmd_q == CMD_PRE);
  assign is_post   = (cmd_q == CMD_POST);
  assign is_finish = (cmd_q == CMD_FINISH);
  assign len_ok    = (len_q <= LenW'(MaxLen));
  assign len6      = len_q[DepthW-1:0];

  // host bits cleared; the step past the prefix carries out when all prefix bits are one
  assign mask  = ~({AddrW{1'b1}} >> len6);
  assign maddr = addr_q & mask;
  assign step  = (AddrW+1)'(1) << (DepthW'(MaxLen) - len6);
  assign sum   = {1'b0, maddr} + step;

  assign fill_val  = rdv_q ? rd_q : '0;
  assign mem_we    = ctl_i.fill_step | ctl_i.set_level;
  assign mem_waddr = ctl_i.fill_step ? depth_q + DepthW'(1) : len6;
  assign mem_wdata = ctl_i.fill_step ? fill_val : val_q;

  assign new_val  = is_post ? fill_val : val_q;
  assign out_free = !out_valid_q || out_ready_i;
  assign emit     = (ctl_i.update && (new_val != open_val_q) && (addr_q != open_start_q)
                     && (open_val_q != '0))
                 || (ctl_i.flush && (open_val_q != '0));

  always_comb begin
    sts_o              = '0;
    sts_o.is_pre       = is_pre;
    sts_o.is_post      = is_post;
    sts_o.is_finish    = is_finish;
    sts_o.item_ok      = (is_pre || is_post) && len_ok;
    sts_o.wraps        = sum[AddrW];
    sts_o.depth_lt_len = (depth_q < len6);
    sts_o.out_free     = out_free;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q  <= item_i.command;
      addr_q <= item_i.prefix_addr;
      len_q  <= item_i.prefix_len;
      val_q  <= item_i.value_id[StoreW-1:0];
    end else if (ctl_i.prep) begin
      addr_q <= is_post ? sum[AddrW-1:0] : maddr;
    end
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (ctl_i.rd_level) begin
      rd_q  <= mem[depth_q];
      rdv_q <= valid_q[depth_q];
    end
    if (emit) begin
      out_q.range_start <= open_start_q;
      out_q.range_end   <= ctl_i.flush ? {AddrW{1'b1}} : addr_q - AddrW'(1);
      out_q.range_value <= ValueW'(open_val_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      depth_q      <= '0;
      open_start_q <= '0;
      open_val_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (ctl_i.flush) begin
        valid_q      <= '0;
        depth_q      <= '0;
        open_start_q <= '0;
        open_val_q   <= '0;
      end else begin
        if (mem_we) begin
          valid_q[mem_waddr] <= 1'b1;
        end
        if (ctl_i.fill_step) begin
          depth_q <= depth_q + DepthW'(1);
        end else if (ctl_i.post_depth) begin
          // level reached by the carry: 31 minus the lowest set bit of the stepped address
          depth_q <= DepthW'(MaxLen - 1) - DepthW'(trailing_zeros(addr_q));
        end
        if (ctl_i.update && (new_val != open_val_q)) begin
          if (addr_q != open_start_q) begin
            open_start_q <= addr_q;
          end
          open_val_q <= new_val;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

/* rtl/prefix_walk_to_ranges_core.sv */
// Prefix-walk range builder: turns pre/post visit events into merged address ranges.
//
// in_i carries one visit event per transfer (command, prefix_addr, prefix_len, value_id);
// out_o carries one merged range per transfer (range_start, range_end, range_value).
// Events are taken one at a time; in_i.ready is high only while the block is idle.
// Ignored events (unused command, length above 32, wrapping post visit) go back to
// idle straight from decode. The level stack has a single write port, so growing
// it copies the inherited value one level per cycle. A range appears on out_o the
// cycle after the event that closes it. The output register holds one range. A
// pre visit, post visit or finish holds in its last step while that register is
// occupied and not being taken, whether or not the event closes a range, and
// nothing is accepted meanwhile. Reset clears the stack, the open range and the
// output register at once; finish loads the open range, if its value is nonzero,
// and clears the stack and the open range.
`default_nettype none

module prefix_walk_to_ranges_core #(
  parameter int VALUE_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  pwr_stream_if.sink   in_i,
  pwr_stream_if.source out_o
);
  import pwr_pkg::*;

  ctl_t      ctl;
  sts_t      sts;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_item;

  pwr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  pwr_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (in_i.payload),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .out_item_o  (out_item)
  );

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid;
  assign out_o.payload = out_item;

  a_value_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.payload.range_value != '0)
    else $error("range transfer offered with a zero value");

  a_update_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.update || ctl.flush) |-> sts.out_free)
    else $error("range update while the output register is occupied");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.load |=> !in_i.ready)
    else $error("input ready straight after an accepted event");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.fill_step |-> sts.depth_lt_len)
    else $error("stack fill beyond the prefix length");

endmodule

`default_nettype wire
